// ----- rtl/gsr_pkg.sv -----
// Shared constants, codes and types of the Gauss-Seidel grid relaxation block.
`default_nettype none

package gsr_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DATA_W     = 32;
  localparam int CHG_W      = 31;
  localparam int SWP_W      = 16;
  localparam int SIZE_W     = 7;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd3;

  localparam logic [SIZE_W-1:0] ROWS_RST   = 7'd64;
  localparam logic [SIZE_W-1:0] COLS_RST   = 7'd64;
  localparam logic [SWP_W-1:0]  SWEEPS_RST = 16'd100;
  localparam logic [CHG_W-1:0]  TOL_RST    = 31'd1;
  localparam logic [SIZE_W-1:0] MIN_SIZE   = 7'd3;
  localparam logic [CHG_W-1:0]  CHG_SAT    = {CHG_W{1'b1}};

  // Which working register takes the registered read data.
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_LEFT,
    CAP_PREV,
    CAP_UP,
    CAP_DOWN,
    CAP_RIGHT
  } cap_e;

  // What the output register is loaded with.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_READ,
    KIND_RELAX
  } kind_e;

  typedef struct packed {
    logic              mem_re;
    logic [ADDR_W-1:0] raddr;
    logic              mem_we;
    logic              wsel_avg;
    logic [ADDR_W-1:0] waddr;
    cap_e              cap;
    logic              cell_wb;
    logic              clr_max;
    logic              out_load;
    kind_e             out_kind;
    logic [SWP_W-1:0]  sweeps;
    logic              conv;
  } gsr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic below_tol;
  } gsr_stat_t;

endpackage

`default_nettype wire

// ----- rtl/gsr_if.sv -----
// Valid/ready channel interfaces for the command input and the result output.
`default_nettype none

interface gsr_in_if import gsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface gsr_out_if import gsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [SWP_W-1:0]         sweeps_done;
  logic [CHG_W-1:0]         max_change;
  logic                     converged;

  modport source (output valid, read_value, sweeps_done, max_change, converged, input ready);
  modport sink   (input valid, read_value, sweeps_done, max_change, converged, output ready);
endinterface

`default_nettype wire

// ----- rtl/gsr_ctrl.sv -----
// Controller: command decode, sweep sequencing and grid address generation.
`default_nettype none

module gsr_ctrl import gsr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [CMD_W-1:0]  in_cmd_i,
  input  wire logic [ROW_W-1:0]  in_row_i,
  input  wire logic [COL_W-1:0]  in_col_i,
  output logic                   in_ready_o,
  input  wire logic [SIZE_W-1:0] grid_rows_i,
  input  wire logic [SIZE_W-1:0] grid_cols_i,
  input  wire logic [SWP_W-1:0]  max_sweeps_i,
  input  wire gsr_stat_t         stat_i,
  output gsr_cmd_t               cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_HOLD  = 4'd1;
  localparam logic [3:0] ST_ROW_L = 4'd2;
  localparam logic [3:0] ST_ROW_P = 4'd3;
  localparam logic [3:0] ST_UP    = 4'd4;
  localparam logic [3:0] ST_DN    = 4'd5;
  localparam logic [3:0] ST_RT    = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_WB    = 4'd8;
  localparam logic [3:0] ST_CHK   = 4'd9;

  localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);
  localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);
  localparam logic [COL_W-1:0] COL_ZERO = '0;

  logic [3:0]       state_q, state_d;
  logic [ROW_W-1:0] i_q, i_d;
  logic [COL_W-1:0] j_q, j_d;
  logic [SWP_W-1:0] done_q, done_d;
  logic             conv_q, conv_d;
  kind_e            kind_q, kind_d;

  logic [SIZE_W-1:0] rows_c, cols_c;
  logic [ROW_W-1:0]  last_row;
  logic [COL_W-1:0]  last_col;
  logic [SWP_W-1:0]  limit;
  logic [SWP_W-1:0]  done_inc;
  logic [ROW_W-1:0]  i_dec, i_inc;
  logic [COL_W-1:0]  j_inc;

  // Sizes outside the supported range are held to it at relax time.
  always_comb begin
    if (grid_rows_i < MIN_SIZE) begin
      rows_c = MIN_SIZE;
    end else if (grid_rows_i > SIZE_W'(MAX_ROWS)) begin
      rows_c = SIZE_W'(MAX_ROWS);
    end else begin
      rows_c = grid_rows_i;
    end
    if (grid_cols_i < MIN_SIZE) begin
      cols_c = MIN_SIZE;
    end else if (grid_cols_i > SIZE_W'(MAX_COLS)) begin
      cols_c = SIZE_W'(MAX_COLS);
    end else begin
      cols_c = grid_cols_i;
    end
  end

  assign last_row = ROW_W'(rows_c - SIZE_W'(2));
  assign last_col = COL_W'(cols_c - SIZE_W'(2));
  assign limit    = (max_sweeps_i == '0) ? SWP_W'(1) : max_sweeps_i;
  assign done_inc = done_q + SWP_W'(1);
  assign i_dec    = i_q - ROW_ONE;
  assign i_inc    = i_q + ROW_ONE;
  assign j_inc    = j_q + COL_ONE;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    done_d  = done_q;
    conv_d  = conv_q;
    kind_d  = kind_q;

    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.cap      = CAP_NONE;
    cmd_o.out_kind = kind_q;
    cmd_o.sweeps   = done_q;
    cmd_o.conv     = conv_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_READ: begin
              cmd_o.mem_re = 1'b1;
              cmd_o.raddr  = {in_row_i, in_col_i};
              kind_d       = KIND_READ;
              state_d      = ST_HOLD;
            end
            CMD_RELAX: begin
              i_d           = ROW_ONE;
              j_d           = COL_ONE;
              done_d        = '0;
              cmd_o.clr_max = 1'b1;
              state_d       = ST_ROW_L;
            end
            default: begin
              // A cell write, or an unknown command that only answers zero.
              if (in_cmd_i == CMD_WRITE) begin
                cmd_o.mem_we = 1'b1;
                cmd_o.waddr  = {in_row_i, in_col_i};
              end
              kind_d = KIND_ZERO;
              if (stat_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = KIND_ZERO;
              end else begin
                state_d = ST_HOLD;
              end
            end
          endcase
        end
      end
      ST_HOLD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ROW_L: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.raddr  = {i_q, COL_ZERO};
        state_d      = ST_ROW_P;
      end
      ST_ROW_P: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.raddr  = {i_q, j_q};
        cmd_o.cap    = CAP_LEFT;
        state_d      = ST_UP;
      end
      ST_UP: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.raddr  = {i_dec, j_q};
        // The old value of the first cell of a row arrives here.
        cmd_o.cap    = (j_q == COL_ONE) ? CAP_PREV : CAP_NONE;
        state_d      = ST_DN;
      end
      ST_DN: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.raddr  = {i_inc, j_q};
        cmd_o.cap    = CAP_UP;
        state_d      = ST_RT;
      end
      ST_RT: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.raddr  = {i_q, j_inc};
        cmd_o.cap    = CAP_DOWN;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.cap = CAP_RIGHT;
        state_d   = ST_WB;
      end
      ST_WB: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.wsel_avg = 1'b1;
        cmd_o.waddr    = {i_q, j_q};
        cmd_o.cell_wb  = 1'b1;
        if (j_q == last_col) begin
          if (i_q == last_row) begin
            state_d = ST_CHK;
          end else begin
            i_d     = i_inc;
            j_d     = COL_ONE;
            state_d = ST_ROW_L;
          end
        end else begin
          j_d     = j_inc;
          state_d = ST_UP;
        end
      end
      ST_CHK: begin
        done_d = done_inc;
        if (stat_i.below_tol || (done_inc == limit)) begin
          conv_d  = stat_i.below_tol;
          kind_d  = KIND_RELAX;
          state_d = ST_HOLD;
        end else begin
          cmd_o.clr_max = 1'b1;
          i_d           = ROW_ONE;
          j_d           = COL_ONE;
          state_d       = ST_ROW_L;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      done_q  <= '0;
      conv_q  <= 1'b0;
      kind_q  <= KIND_ZERO;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      done_q  <= done_d;
      conv_q  <= conv_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gsr_datapath.sv -----
// Datapath: grid memory, stencil registers, averaging, change tracking and result register.
`default_nettype none

module gsr_datapath import gsr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gsr_cmd_t                 cmd_i,
  output gsr_stat_t                     stat_o,
  input  wire logic signed [DATA_W-1:0] in_value_i,
  input  wire logic [CHG_W-1:0]         tolerance_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      out_read_value_o,
  output logic [SWP_W-1:0]              out_sweeps_done_o,
  output logic [CHG_W-1:0]              out_max_change_o,
  output logic                          out_converged_o
);

  localparam int SUM_W  = DATA_W + 2;
  localparam int DIFF_W = DATA_W + 1;

  logic signed [DATA_W-1:0] mem [MAX_ROWS*MAX_COLS];

  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] left_q, prev_q, up_q, dn_q, rt_q, avg_q;
  logic [CHG_W-1:0]         max_q;
  logic                     out_valid_q;

  logic signed [SUM_W-1:0]  sum;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [CHG_W-1:0]         chg;
  logic signed [DATA_W-1:0] wdata;

  // Four neighbours summed at full width; the right neighbour is still on the read port.
  assign sum  = SUM_W'(left_q) + SUM_W'(up_q) + SUM_W'(dn_q) + SUM_W'(rdata_q);
  assign diff = DIFF_W'(prev_q) - DIFF_W'(avg_q);
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign chg  = (mag[DIFF_W-1:CHG_W] != '0) ? CHG_SAT : mag[CHG_W-1:0];

  assign wdata = cmd_i.wsel_avg ? avg_q : in_value_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[cmd_i.waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_re) begin
      rdata_q <= mem[cmd_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap)
      CAP_LEFT:  left_q <= rdata_q;
      CAP_PREV:  prev_q <= rdata_q;
      CAP_UP:    up_q   <= rdata_q;
      CAP_DOWN:  dn_q   <= rdata_q;
      CAP_RIGHT: begin
        rt_q  <= rdata_q;
        avg_q <= sum[SUM_W-1:2];
      end
      default: ;
    endcase
    // The new value is the left neighbour of the next cell, and the old
    // right neighbour becomes its previous value.
    if (cmd_i.cell_wb) begin
      left_q <= avg_q;
      prev_q <= rt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cmd_i.clr_max) begin
      max_q <= '0;
    end else if (cmd_i.cell_wb && (chg > max_q)) begin
      max_q <= chg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        KIND_READ: begin
          out_read_value_o  <= rdata_q;
          out_sweeps_done_o <= '0;
          out_max_change_o  <= '0;
          out_converged_o   <= 1'b0;
        end
        KIND_RELAX: begin
          out_read_value_o  <= '0;
          out_sweeps_done_o <= cmd_i.sweeps;
          out_max_change_o  <= max_q;
          out_converged_o   <= cmd_i.conv;
        end
        default: begin
          out_read_value_o  <= '0;
          out_sweeps_done_o <= '0;
          out_max_change_o  <= '0;
          out_converged_o   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.below_tol = (max_q < tolerance_i);

endmodule

`default_nettype wire

// ----- rtl/gauss_seidel_grid_relaxation.sv -----
// Top level: configuration registers, controller and datapath of the grid relaxation block.
//
//   Channel   Direction  Transfer when   Payload
//   in_i      sink       valid & ready   cmd, row, col, value
//   out_o     source     valid & ready   read_value, sweeps_done, max_change, converged
//   cfg       write      cfg_we_i        cfg_idx_i, cfg_data_i
//
// A cell write or an unknown command loads the result register in the accepting cycle when it is free.
// A cell read does one memory read, then one result load.
// A relax of S sweeps: every cell costs three reads on the single grid read port, a sum and
// a write-back, each row two more reads, and each sweep ends with a convergence check; the
// result is loaded after the last sweep.
// The input stalls while a command is in progress or its result cannot be loaded.
// Reset clears the control state and sets the configuration registers to their defaults; the grid is not cleared.
`default_nettype none

module gauss_seidel_grid_relaxation import gsr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  gsr_in_if.sink                     in_i,
  gsr_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SIZE_W-1:0] grid_rows_q;
  logic [SIZE_W-1:0] grid_cols_q;
  logic [SWP_W-1:0]  max_sweeps_q;
  logic [CHG_W-1:0]  tolerance_q;

  gsr_cmd_t  cmd;
  gsr_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= ROWS_RST;
      grid_cols_q  <= COLS_RST;
      max_sweeps_q <= SWEEPS_RST;
      tolerance_q  <= TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_ROWS:  grid_rows_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_GRID_COLS:  grid_cols_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_MAX_SWEEPS: max_sweeps_q <= cfg_data_i[SWP_W-1:0];
        CFG_TOLERANCE:  tolerance_q  <= cfg_data_i[CHG_W-1:0];
        default: ;
      endcase
    end
  end

  gsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_cmd_i     (in_i.cmd),
    .in_row_i     (in_i.row),
    .in_col_i     (in_i.col),
    .in_ready_o   (in_i.ready),
    .grid_rows_i  (grid_rows_q),
    .grid_cols_i  (grid_cols_q),
    .max_sweeps_i (max_sweeps_q),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  gsr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_value_i        (in_i.value),
    .tolerance_i       (tolerance_q),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_read_value_o  (out_o.read_value),
    .out_sweeps_done_o (out_o.sweeps_done),
    .out_max_change_o  (out_o.max_change),
    .out_converged_o   (out_o.converged)
  );

endmodule

`default_nettype wire
